@@ src/rc4_stream_cipher_macros.svh @@
// assertion macros for the rc4 stream cipher
`ifndef RC4_STREAM_CIPHER_MACROS_SVH
`define RC4_STREAM_CIPHER_MACROS_SVH

`ifndef SYNTHESIS

`define RC4_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define RC4_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RC4_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)

`define RC4_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ src/rc4_pkg.sv @@
// shared types and constants of the rc4 stream cipher
`default_nettype none

package rc4_pkg;

  localparam int BYTE_W        = 8;
  localparam int SBOX_DEPTH    = 256;
  localparam int SBOX_AW       = 8;
  localparam int MAX_KEY_BYTES = 256;
  localparam int KEY_CNT_W     = 9;

  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_DATA = 1'b1;

  typedef struct packed {
    logic              op;
    logic [BYTE_W-1:0] key_byte;
    logic              key_last;
    logic [BYTE_W-1:0] data_byte;
    logic              data_last;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              out_last;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic out_free;
  } core_ctl_t;

  typedef struct packed {
    logic ready;
    logic res_valid;
  } core_stat_t;

endpackage

`default_nettype wire

@@ src/rc4_stream_cipher.sv @@
// rc4 stream cipher top level: a data request steps through states PRJ, PWI and PWJ
// (PWJ waits while output is blocked) before the result is registered; no new request
// is taken meanwhile; a key byte without last mark leaves the block idle
// key byte with last mark busies the block for 256 s-box fill plus 256 swap steps
// after reset the s-box is filled with the identity, no request taken
// a finished result waits in the output register while the next request is taken
`default_nettype none

module rc4_stream_cipher (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire rc4_pkg::in_item_t  in_item,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output rc4_pkg::out_item_t     out_item
);

  rc4_pkg::core_ctl_t  core_ctl;
  rc4_pkg::core_stat_t core_stat;
  rc4_pkg::out_item_t  core_res;

  logic               out_valid_r, out_valid_nxt;
  rc4_pkg::out_item_t out_item_r;

  assign in_stall          = !core_stat.ready;
  assign core_ctl.start    = in_valid && core_stat.ready;
  assign core_ctl.out_free = !out_valid_r || !out_stall;

  rc4_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (core_ctl),
    .req   (in_item),
    .stat  (core_stat),
    .res   (core_res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (core_stat.res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (core_stat.res_valid) begin
        out_item_r <= core_res;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

@@ src/rc4_core.sv @@
// rc4 sequencer with s-box memory, key store and shared swap datapath
`default_nettype none
`include "rc4_stream_cipher_macros.svh"

module rc4_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rc4_pkg::core_ctl_t ctl,
  input  wire rc4_pkg::in_item_t  req,
  output rc4_pkg::core_stat_t    stat,
  output rc4_pkg::out_item_t     res
);

  typedef enum logic [3:0] {
    ST_FILL,
    ST_IDLE,
    ST_KFILL,
    ST_KRD,
    ST_KJ,
    ST_KWI,
    ST_KWJ,
    ST_PRJ,
    ST_PWI,
    ST_PWJ
  } state_t;

  localparam logic [rc4_pkg::SBOX_AW-1:0] CNT_LAST =
    rc4_pkg::SBOX_AW'(rc4_pkg::SBOX_DEPTH - 1);
  localparam logic [rc4_pkg::KEY_CNT_W-1:0] KEY_MAX =
    rc4_pkg::KEY_CNT_W'(rc4_pkg::MAX_KEY_BYTES);

  logic [rc4_pkg::BYTE_W-1:0] sbox_mem [rc4_pkg::SBOX_DEPTH];
  logic [rc4_pkg::BYTE_W-1:0] key_mem  [rc4_pkg::SBOX_DEPTH];

  state_t                       state_r, state_nxt;
  logic [rc4_pkg::SBOX_AW-1:0]  cnt_r, cnt_nxt;
  logic [rc4_pkg::SBOX_AW-1:0]  i_r, i_nxt;
  logic [rc4_pkg::SBOX_AW-1:0]  j_r, j_nxt;
  logic [rc4_pkg::SBOX_AW-1:0]  kidx_r, kidx_nxt;
  logic [rc4_pkg::KEY_CNT_W-1:0] key_count_r, key_count_nxt;
  logic [rc4_pkg::BYTE_W-1:0]   si_r, si_nxt;
  logic [rc4_pkg::BYTE_W-1:0]   sj_r, sj_nxt;
  logic [rc4_pkg::BYTE_W-1:0]   dbyte_r, dbyte_nxt;
  logic                         dlast_r, dlast_nxt;

  logic                         mem_we, mem_re;
  logic [rc4_pkg::SBOX_AW-1:0]  mem_waddr, mem_raddr;
  logic [rc4_pkg::BYTE_W-1:0]   mem_wdata, mem_rdata_r;

  logic                         key_we, key_re;
  logic [rc4_pkg::BYTE_W-1:0]   key_rdata_r;

  logic [rc4_pkg::SBOX_AW-1:0]  t_addr;
  logic [rc4_pkg::BYTE_W-1:0]   ks;
  logic                         kidx_wrap;

  assign t_addr    = si_r + sj_r;
  assign kidx_wrap = ({1'b0, kidx_r} + rc4_pkg::KEY_CNT_W'(1)) >= key_count_r;

  always_comb begin
    if (t_addr == j_r) begin
      ks = si_r;
    end else if (t_addr == i_r) begin
      ks = sj_r;
    end else begin
      ks = mem_rdata_r;
    end
  end

  assign stat.ready     = (state_r == ST_IDLE);
  assign stat.res_valid = (state_r == ST_PWJ) && ctl.out_free;
  assign res.out_byte   = dbyte_r ^ ks;
  assign res.out_last   = dlast_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    kidx_nxt      = kidx_r;
    key_count_nxt = key_count_r;
    si_nxt        = si_r;
    sj_nxt        = sj_r;
    dbyte_nxt     = dbyte_r;
    dlast_nxt     = dlast_r;
    mem_we        = 1'b0;
    mem_waddr     = cnt_r;
    mem_wdata     = cnt_r;
    mem_re        = 1'b0;
    mem_raddr     = cnt_r;
    key_we        = 1'b0;
    key_re        = 1'b0;

    unique case (state_r)
      ST_FILL, ST_KFILL: begin
        mem_we  = 1'b1;
        cnt_nxt = cnt_r + rc4_pkg::SBOX_AW'(1);
        if (cnt_r == CNT_LAST) begin
          state_nxt = (state_r == ST_FILL) ? ST_IDLE : ST_KRD;
        end
      end
      ST_IDLE: begin
        if (ctl.start) begin
          if (req.op == rc4_pkg::OP_DATA) begin
            i_nxt     = i_r + rc4_pkg::SBOX_AW'(1);
            mem_re    = 1'b1;
            mem_raddr = i_nxt;
            dbyte_nxt = req.data_byte;
            dlast_nxt = req.data_last;
            state_nxt = ST_PRJ;
          end else begin
            if (key_count_r < KEY_MAX) begin
              key_we        = 1'b1;
              key_count_nxt = key_count_r + rc4_pkg::KEY_CNT_W'(1);
            end
            if (req.key_last) begin
              cnt_nxt   = '0;
              j_nxt     = '0;
              kidx_nxt  = '0;
              state_nxt = ST_KFILL;
            end
          end
        end
      end
      ST_KRD: begin
        mem_re    = 1'b1;
        key_re    = 1'b1;
        state_nxt = ST_KJ;
      end
      ST_KJ: begin
        si_nxt    = mem_rdata_r;
        j_nxt     = j_r + mem_rdata_r + key_rdata_r;
        mem_re    = 1'b1;
        mem_raddr = j_nxt;
        state_nxt = ST_KWI;
      end
      ST_KWI: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata_r;
        state_nxt = ST_KWJ;
      end
      ST_KWJ: begin
        mem_we    = 1'b1;
        mem_waddr = j_r;
        mem_wdata = si_r;
        kidx_nxt  = kidx_wrap ? '0 : kidx_r + rc4_pkg::SBOX_AW'(1);
        cnt_nxt   = cnt_r + rc4_pkg::SBOX_AW'(1);
        if (cnt_r == CNT_LAST) begin
          i_nxt         = '0;
          j_nxt         = '0;
          key_count_nxt = '0;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_KRD;
        end
      end
      ST_PRJ: begin
        si_nxt    = mem_rdata_r;
        j_nxt     = j_r + mem_rdata_r;
        mem_re    = 1'b1;
        mem_raddr = j_nxt;
        state_nxt = ST_PWI;
      end
      ST_PWI: begin
        sj_nxt    = mem_rdata_r;
        mem_we    = 1'b1;
        mem_waddr = i_r;
        mem_wdata = mem_rdata_r;
        mem_re    = 1'b1;
        mem_raddr = si_r + mem_rdata_r;
        state_nxt = ST_PWJ;
      end
      ST_PWJ: begin
        if (ctl.out_free) begin
          mem_we    = 1'b1;
          mem_waddr = j_r;
          mem_wdata = si_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      cnt_r       <= '0;
      i_r         <= '0;
      j_r         <= '0;
      kidx_r      <= '0;
      key_count_r <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      kidx_r      <= kidx_nxt;
      key_count_r <= key_count_nxt;
      si_r        <= si_nxt;
      sj_r        <= sj_nxt;
      dbyte_r     <= dbyte_nxt;
      dlast_r     <= dlast_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      sbox_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= sbox_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_count_r[rc4_pkg::SBOX_AW-1:0]] <= req.key_byte;
    end
    if (key_re) begin
      key_rdata_r <= key_mem[kidx_r];
    end
  end

  `RC4_ASSERT_IMP(a_key_count_sat, clk, rst_n, 1'b1, key_count_r <= KEY_MAX,
    "key count beyond store size")
  `RC4_ASSERT_NXT(a_data_start, clk, rst_n,
    state_r == ST_IDLE && ctl.start && req.op == rc4_pkg::OP_DATA,
    state_r == ST_PRJ && i_r == $past(i_r) + rc4_pkg::SBOX_AW'(1),
    "data request did not start keystream step")
  `RC4_ASSERT_NXT(a_ksa_done, clk, rst_n, state_r == ST_KWJ && cnt_r == CNT_LAST,
    state_r == ST_IDLE && key_count_r == '0 && i_r == '0 && j_r == '0,
    "key schedule did not finish cleanly")
  `RC4_ASSERT_NXT(a_res_hold, clk, rst_n, state_r == ST_PWJ && !ctl.out_free,
    state_r == ST_PWJ && $stable(j_r) && $stable(si_r) && $stable(sj_r),
    "keystream step lost state while output blocked")

endmodule

`default_nettype wire

@@ bench/tb_rc4_stream_cipher.sv @@
// self-checking testbench for the rc4 stream cipher with its own keystream predictor
`default_nettype none

module tb_rc4_stream_cipher;

  typedef struct packed {
    rc4_pkg::in_item_t  req;
    logic               known;
    rc4_pkg::out_item_t res;
  } dir_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  rc4_pkg::in_item_t  in_item;
  logic               out_valid;
  logic               out_stall = 1'b1;
  rc4_pkg::out_item_t out_item;

  logic               drv_known;
  rc4_pkg::out_item_t drv_known_res;
  logic               hold_on;
  bit                 rand_phase;
  bit                 tx_calm;
  bit                 rx_calm;
  int                 rx_wait;
  int                 mismatches;

  logic [rc4_pkg::BYTE_W-1:0]    sbox_m [rc4_pkg::SBOX_DEPTH];
  logic [rc4_pkg::BYTE_W-1:0]    key_mem [rc4_pkg::SBOX_DEPTH];
  logic [rc4_pkg::KEY_CNT_W-1:0] key_count;
  logic [rc4_pkg::SBOX_AW-1:0]   idx_i;
  logic [rc4_pkg::SBOX_AW-1:0]   idx_j;

  rc4_pkg::out_item_t pending_out [$];
  dir_row_t           dir_tab [$];

  rc4_stream_cipher u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #36_000_000;
    $display("FAIL rc4_stream_cipher");
    $finish;
  end

  function automatic dir_row_t mk_row(logic op, logic [7:0] kb, logic kl, logic [7:0] db,
                                      logic dl, logic known, logic [7:0] ob, logic ol);
    dir_row_t r;
    r.req.op        = op;
    r.req.key_byte  = kb;
    r.req.key_last  = kl;
    r.req.data_byte = db;
    r.req.data_last = dl;
    r.known         = known;
    r.res.out_byte  = ob;
    r.res.out_last  = ol;
    return r;
  endfunction

  task automatic predict_request(input rc4_pkg::in_item_t req, output bit got,
                                 output rc4_pkg::out_item_t res);
    logic [rc4_pkg::BYTE_W-1:0] si, sj, jj, t;
    int len, k;
    got = 1'b0;
    res = '0;
    if (req.op == rc4_pkg::OP_KEY) begin
      if (key_count < rc4_pkg::MAX_KEY_BYTES) begin
        key_mem[key_count[rc4_pkg::SBOX_AW-1:0]] = req.key_byte;
        key_count = key_count + 1'b1;
      end
      if (req.key_last) begin
        len = (key_count == 0) ? 1 : int'(key_count);
        for (k = 0; k < rc4_pkg::SBOX_DEPTH; k++) begin
          sbox_m[rc4_pkg::SBOX_AW'(k)] = k[rc4_pkg::BYTE_W-1:0];
        end
        jj = '0;
        for (k = 0; k < rc4_pkg::SBOX_DEPTH; k++) begin
          jj = jj + sbox_m[rc4_pkg::SBOX_AW'(k)] + key_mem[rc4_pkg::SBOX_AW'(k % len)];
          t = sbox_m[rc4_pkg::SBOX_AW'(k)];
          sbox_m[rc4_pkg::SBOX_AW'(k)] = sbox_m[jj];
          sbox_m[jj] = t;
        end
        idx_i = '0;
        idx_j = '0;
        key_count = '0;
      end
    end else begin
      idx_i = idx_i + 1'b1;
      si = sbox_m[idx_i];
      idx_j = idx_j + si;
      sj = sbox_m[idx_j];
      sbox_m[idx_i] = sj;
      sbox_m[idx_j] = si;
      t = si + sj;
      res.out_byte = req.data_byte ^ sbox_m[t];
      res.out_last = req.data_last;
      got = 1'b1;
    end
  endtask

  initial begin : model_init
    int k;
    for (k = 0; k < rc4_pkg::SBOX_DEPTH; k++) begin
      sbox_m[rc4_pkg::SBOX_AW'(k)] = k[rc4_pkg::BYTE_W-1:0];
      key_mem[rc4_pkg::SBOX_AW'(k)] = '0;
    end
    key_count = '0;
    idx_i = '0;
    idx_j = '0;
  end

  // request and result monitor
  always @(posedge clk) begin : monitor
    bit got;
    rc4_pkg::out_item_t res;
    rc4_pkg::out_item_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_request(in_item, got, res);
        if (got) pending_out.push_back(drv_known ? drv_known_res : res);
      end
      if (out_valid && !out_stall) begin
        if (pending_out.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result byte %02h last %0b", out_item.out_byte, out_item.out_last);
        end else begin
          want = pending_out.pop_front();
          if (want.out_byte !== out_item.out_byte || want.out_last !== out_item.out_last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                       want.out_byte, want.out_last, out_item.out_byte, out_item.out_last);
          end
        end
      end
    end
  end

  // result side stall
  always @(posedge clk) begin : receiver
    int w;
    if (!rst_n) begin
      out_stall <= 1'b1;
      rx_wait <= 0;
    end else if (out_valid && !out_stall) begin
      if ($urandom_range(0, 49) == 0) rx_calm = !rx_calm;
      w = rx_calm ? 0 : int'($urandom_range(0, 4));
      rx_wait <= w;
      out_stall <= (w != 0) || hold_on;
    end else if (rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
      out_stall <= (rx_wait > 1) || hold_on;
    end else begin
      out_stall <= hold_on;
    end
  end

  // long hold-off on the result side while data requests keep coming
  initial begin
    hold_on = 1'b0;
    wait (rand_phase);
    @(posedge clk);
    while (!(out_valid && in_valid && in_item.op == rc4_pkg::OP_DATA)) @(posedge clk);
    hold_on <= 1'b1;
    repeat (300) @(posedge clk);
    hold_on <= 1'b0;
  end

  task automatic send_request(input rc4_pkg::in_item_t req, input logic known,
                              input rc4_pkg::out_item_t kres);
    int gap;
    if ($urandom_range(0, 49) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : int'($urandom_range(0, 4));
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_item       <= req;
    drv_known     <= known;
    drv_known_res <= kres;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin : stimulus
    rc4_pkg::in_item_t req;
    int n_items, klen, mlen, k;
    bit first_group;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    drv_known = 1'b0;
    drv_known_res = '0;
    rand_phase = 1'b0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    mismatches = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // keystream from the reset s-box, unused key fields set
    dir_tab.push_back(mk_row(rc4_pkg::OP_DATA, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 8'h02, 1'b0));
    dir_tab.push_back(mk_row(rc4_pkg::OP_DATA, 8'hff, 1'b1, 8'hff, 1'b1, 1'b1, 8'hfa, 1'b1));
    dir_tab.push_back(mk_row(rc4_pkg::OP_DATA, 8'ha5, 1'b1, 8'h00, 1'b0, 1'b1, 8'h07, 1'b0));
    // two byte key, unused data fields set
    dir_tab.push_back(mk_row(rc4_pkg::OP_KEY,  8'h00, 1'b0, 8'hff, 1'b1, 1'b0, 8'h00, 1'b0));
    dir_tab.push_back(mk_row(rc4_pkg::OP_KEY,  8'hff, 1'b1, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0));
    dir_tab.push_back(mk_row(rc4_pkg::OP_DATA, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0));
    dir_tab.push_back(mk_row(rc4_pkg::OP_DATA, 8'h00, 1'b0, 8'hff, 1'b1, 1'b0, 8'h00, 1'b0));
    dir_tab.push_back(mk_row(rc4_pkg::OP_DATA, 8'hff, 1'b0, 8'h5a, 1'b0, 1'b0, 8'h00, 1'b0));
    // one byte key
    dir_tab.push_back(mk_row(rc4_pkg::OP_KEY,  8'h01, 1'b1, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0));
    dir_tab.push_back(mk_row(rc4_pkg::OP_DATA, 8'h00, 1'b0, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0));
    dir_tab.push_back(mk_row(rc4_pkg::OP_DATA, 8'h00, 1'b0, 8'hff, 1'b0, 1'b0, 8'h00, 1'b0));
    // three byte key
    dir_tab.push_back(mk_row(rc4_pkg::OP_KEY,  8'h80, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0));
    dir_tab.push_back(mk_row(rc4_pkg::OP_KEY,  8'h7f, 1'b0, 8'hff, 1'b1, 1'b0, 8'h00, 1'b0));
    dir_tab.push_back(mk_row(rc4_pkg::OP_KEY,  8'hfe, 1'b1, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0));
    dir_tab.push_back(mk_row(rc4_pkg::OP_DATA, 8'h00, 1'b0, 8'h01, 1'b0, 1'b0, 8'h00, 1'b0));
    dir_tab.push_back(mk_row(rc4_pkg::OP_DATA, 8'h00, 1'b0, 8'h80, 1'b1, 1'b0, 8'h00, 1'b0));
    // all-ones key byte
    dir_tab.push_back(mk_row(rc4_pkg::OP_KEY,  8'hff, 1'b1, 8'hff, 1'b1, 1'b0, 8'h00, 1'b0));
    dir_tab.push_back(mk_row(rc4_pkg::OP_DATA, 8'hff, 1'b1, 8'hff, 1'b1, 1'b0, 8'h00, 1'b0));

    foreach (dir_tab[r]) send_request(dir_tab[r].req, dir_tab[r].known, dir_tab[r].res);

    rand_phase = 1'b1;
    first_group = 1'b1;
    n_items = 0;
    while (n_items < 2000) begin
      if (first_group || $urandom_range(0, 3) != 0) begin
        klen = ($urandom_range(0, 15) == 0) ? int'($urandom_range(250, 300))
                                            : int'($urandom_range(1, 16));
        for (k = 0; k < klen; k++) begin
          req.op        = rc4_pkg::OP_KEY;
          req.key_byte  = 8'($urandom_range(0, 255));
          req.key_last  = (k == klen - 1) || ($urandom_range(0, 63) == 0);
          req.data_byte = 8'($urandom_range(0, 255));
          req.data_last = 1'($urandom_range(0, 1));
          send_request(req, 1'b0, '0);
          if (k < rc4_pkg::MAX_KEY_BYTES) n_items++;
        end
      end
      first_group = 1'b0;
      mlen = int'($urandom_range(1, 48));
      for (k = 0; k < mlen; k++) begin
        req.op        = rc4_pkg::OP_DATA;
        req.key_byte  = 8'($urandom_range(0, 255));
        req.key_last  = 1'($urandom_range(0, 1));
        req.data_byte = 8'($urandom_range(0, 255));
        req.data_last = (k == mlen - 1) ^ ($urandom_range(0, 31) == 0);
        send_request(req, 1'b0, '0);
        n_items++;
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_out.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS rc4_stream_cipher");
    end else begin
      $display("FAIL rc4_stream_cipher");
    end
    $finish;
  end

endmodule

`default_nettype wire
